>>> sv/gf256_pkg.sv
// ----------------------------------------------------------------------------
// GF(2^8) arithmetic unit package
// Field constants, microcode word layout, program store and field multiply.
// ----------------------------------------------------------------------------
`default_nettype none

package gf256_pkg;

  localparam int unsigned FIELD_BITS = 8;
  localparam int unsigned POLY_BITS  = FIELD_BITS + 1;
  localparam int unsigned PC_BITS    = 2;
  localparam int unsigned K_BITS     = $clog2(FIELD_BITS);

  typedef logic [FIELD_BITS-1:0] elem_t;
  typedef logic [PC_BITS-1:0]    pc_t;

  // Operation codes of the input transaction.
  localparam logic [1:0] ACT_MUL = 2'd0;
  localparam logic [1:0] ACT_DIV = 2'd1;
  localparam logic [1:0] ACT_POW = 2'd2;

  localparam logic [FIELD_BITS:0] POLY_RESET    = 9'h11D;
  localparam elem_t               DIV_ZERO_CODE = 8'hFF;
  localparam elem_t               ELEM_ONE      = 8'h01;
  localparam elem_t               DIV_EXPONENT  = 8'hFE;

  // Datapath operation selected by one microcode word.
  typedef enum logic [1:0] {
    UOP_NOP      = 2'd0,
    UOP_SQUARE   = 2'd1,  // r = r * r
    UOP_MUL_BASE = 2'd2,  // r = r * base when the current exponent bit is set
    UOP_MUL_A    = 2'd3   // r = r * a when the final-multiply flag is set
  } uop_e;

  typedef struct packed {
    uop_e uop;
    logic loop;    // jump to target while the bit counter is not zero
    logic last;    // transaction result is ready after this step
    pc_t  target;
  } uword_t;

  // Program addresses.
  localparam pc_t STEP_SQ  = 2'd0;
  localparam pc_t STEP_MB  = 2'd1;
  localparam pc_t STEP_FIN = 2'd2;

  function automatic uword_t ucode_rom(input pc_t pc);
    uword_t w;
    case (pc)
      STEP_SQ:  w = '{uop: UOP_SQUARE,   loop: 1'b0, last: 1'b0, target: STEP_SQ};
      STEP_MB:  w = '{uop: UOP_MUL_BASE, loop: 1'b1, last: 1'b0, target: STEP_SQ};
      STEP_FIN: w = '{uop: UOP_MUL_A,    loop: 1'b0, last: 1'b1, target: STEP_SQ};
      default:  w = '{uop: UOP_NOP,      loop: 1'b0, last: 1'b1, target: STEP_SQ};
    endcase
    return w;
  endfunction

  // Carry-less multiply with reduction; fb holds the polynomial below x^8.
  function automatic elem_t gf_mul(input elem_t x, input elem_t y, input elem_t fb);
    elem_t acc;
    elem_t xs;
    logic  top;
    acc = '0;
    xs  = x;
    for (int k = 0; k < FIELD_BITS; k++) begin
      if (y[k]) acc = acc ^ xs;
      top = xs[FIELD_BITS-1];
      xs  = {xs[FIELD_BITS-2:0], 1'b0};
      if (top) xs = xs ^ fb;
    end
    return acc;
  endfunction

endpackage

`default_nettype wire

>>> sv/gf256_mul_div_pow_unit.sv
// ----------------------------------------------------------------------------
// GF(2^8) multiply / divide / power unit
// Microcoded sequencer driving one shared field multiplier.
// ----------------------------------------------------------------------------
// One transaction is processed at a time. A multiply, like the zero-operand
// and divide-by-zero cases, runs only the final step; else divide and power
// run eight passes of a square step and a conditional multiply-by-base step
// (square-and-multiply over the 8-bit exponent, b^254 for divide) plus one
// final step, all through the single multiplier. The result sits in an output
// register, so the next transaction is taken once the sequencer is free; the
// final step waits only while that register is still full. Write the
// polynomial register via cfg_we_i only while idle; the block does not check.
`default_nettype none

module gf256_mul_div_pow_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [gf256_pkg::POLY_BITS-1:0] cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output      logic                          in_ready_o,
  input  wire logic [1:0]                    action_i,
  input  wire logic [gf256_pkg::FIELD_BITS:0] operand_a_i,
  input  wire logic [gf256_pkg::FIELD_BITS-1:0] operand_b_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  output      logic [gf256_pkg::FIELD_BITS-1:0] result_o
);
  import gf256_pkg::*;

  logic [POLY_BITS-1:0] poly_q;
  logic                 busy_q;
  pc_t                  pc_q;
  logic [K_BITS-1:0]    k_q;
  elem_t                r_q, a_q, base_q, exp_q;
  logic                 fin_mul_q;
  logic                 out_valid_q;
  elem_t                result_q;

  elem_t  fb;
  elem_t  a_fold;
  uword_t uw;
  elem_t  mul_y;
  elem_t  prod;
  logic   wr_en;
  logic   stall;
  logic   accept;
  logic   finish;

  assign fb     = poly_q[FIELD_BITS-1:0];
  assign a_fold = operand_a_i[FIELD_BITS-1:0] ^ (operand_a_i[FIELD_BITS] ? fb : '0);
  assign uw     = ucode_rom(pc_q);
  assign accept = in_valid_i && in_ready_o;

  assign in_ready_o  = !busy_q;
  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

  always_comb begin
    mul_y = a_q;
    wr_en = 1'b0;
    case (uw.uop)
      UOP_SQUARE: begin
        mul_y = r_q;
        wr_en = 1'b1;
      end
      UOP_MUL_BASE: begin
        mul_y = base_q;
        wr_en = exp_q[k_q];
      end
      UOP_MUL_A: begin
        mul_y = a_q;
        wr_en = fin_mul_q;
      end
      default: begin
        mul_y = a_q;
        wr_en = 1'b0;
      end
    endcase
  end

  assign prod   = gf_mul(r_q, mul_y, fb);
  assign stall  = uw.last && out_valid_q && !out_ready_i;
  assign finish = busy_q && !stall && uw.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q      <= POLY_RESET;
      busy_q      <= 1'b0;
      pc_q        <= STEP_SQ;
      k_q         <= '0;
      fin_mul_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) poly_q <= cfg_wdata_i;
      if (out_valid_q && out_ready_i && !finish) out_valid_q <= 1'b0;

      if (accept) begin
        busy_q <= 1'b1;
        k_q    <= K_BITS'(FIELD_BITS - 1);
        case (action_i)
          ACT_MUL: begin
            pc_q      <= STEP_FIN;
            fin_mul_q <= 1'b1;
          end
          ACT_DIV: begin
            // Zero dividend or zero divisor finishes with a preset result.
            pc_q      <= (a_fold == '0 || operand_b_i == '0) ? STEP_FIN : STEP_SQ;
            fin_mul_q <= (a_fold != '0 && operand_b_i != '0);
          end
          ACT_POW: begin
            pc_q      <= (operand_a_i == '0) ? STEP_FIN : STEP_SQ;
            fin_mul_q <= 1'b0;
          end
          default: begin
            pc_q      <= STEP_FIN;
            fin_mul_q <= 1'b0;
          end
        endcase
      end else if (busy_q && !stall) begin
        if (uw.last) begin
          busy_q      <= 1'b0;
          out_valid_q <= 1'b1;
        end else if (uw.loop && k_q != '0) begin
          pc_q <= uw.target;
          k_q  <= k_q - 1'b1;
        end else begin
          pc_q <= pc_q + 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_q <= a_fold;
      case (action_i)
        ACT_MUL: begin
          r_q    <= operand_b_i;
          base_q <= operand_b_i;
          exp_q  <= '0;
        end
        ACT_DIV: begin
          base_q <= operand_b_i;
          exp_q  <= DIV_EXPONENT;
          if (a_fold == '0)           r_q <= '0;
          else if (operand_b_i == '0) r_q <= DIV_ZERO_CODE;
          else                        r_q <= ELEM_ONE;
        end
        ACT_POW: begin
          base_q <= a_fold;
          exp_q  <= operand_b_i;
          r_q    <= (operand_a_i == '0) ? '0 : ELEM_ONE;
        end
        default: begin
          base_q <= '0;
          exp_q  <= '0;
          r_q    <= '0;
        end
      endcase
    end else if (busy_q && !stall) begin
      if (wr_en) r_q <= prod;
      if (uw.last) result_q <= wr_en ? prod : r_q;
    end
  end

  // A result only appears when a transaction was in the sequencer.
  a_rose_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(busy_q))
    else $error("result appeared without a transaction in progress");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_q)
    else $error("sequencer did not start after accepting a transaction");

  // The square step is always followed by the conditional multiply step.
  a_step_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && pc_q == STEP_SQ) |=> (busy_q && pc_q == STEP_MB))
    else $error("square step not followed by multiply step");

endmodule

`default_nettype wire

>>> dv/gf256_mul_div_pow_unit_test.sv
// ----------------------------------------------------------------------------
// GF(2^8) multiply / divide / power unit testbench
// Drives multiply, divide and power transactions under several reduction
// polynomials and flow-control patterns, and checks every result against a
// field arithmetic predictor that is kept inside the bench.
// ----------------------------------------------------------------------------
module gf256_mul_div_pow_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import gf256_pkg::*;

  // Action code that the unit does not define; it must return zero.
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned DRAIN_CYCLES  = 40;

  typedef logic [POLY_BITS-1:0] poly_t;

  typedef struct packed {
    logic [1:0] action;
    poly_t      operand_a;
    elem_t      operand_b;
    elem_t      result;
  } field_txn_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  poly_t      cfg_wdata_i;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [1:0] action_i;
  poly_t      operand_a_i;
  elem_t      operand_b_i;
  logic       out_valid_o;
  logic       out_ready_i;
  elem_t      result_o;

  field_txn_t  pending_results[$];
  field_txn_t  oldest_result;
  poly_t       field_poly;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned failures = 0;
  int unsigned cycle_count = 0;

  gf256_mul_div_pow_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .action_i   (action_i),
    .operand_a_i(operand_a_i),
    .operand_b_i(operand_b_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .result_o   (result_o)
  );

  always begin
    #5ns clk_i = 1'b1;
    #5ns clk_i = 1'b0;
  end

  // Full carry-less product first, then fold the upper terms down with
  // x^8 = taps, highest term first.
  function automatic elem_t field_mul(input elem_t x, input elem_t y, input elem_t taps);
    logic [2*FIELD_BITS-2:0] wide;
    wide = '0;
    for (int i = 0; i < FIELD_BITS; i++) begin
      if (y[i]) wide = wide ^ ((2*FIELD_BITS-1)'(x) << i);
    end
    for (int i = 2*FIELD_BITS-2; i >= FIELD_BITS; i--) begin
      if (wide[i]) begin
        wide[i] = 1'b0;
        wide = wide ^ ((2*FIELD_BITS-1)'(taps) << (i - FIELD_BITS));
      end
    end
    return wide[FIELD_BITS-1:0];
  endfunction

  function automatic elem_t field_pow(input elem_t base, input elem_t expo, input elem_t taps);
    elem_t acc;
    acc = ELEM_ONE;
    for (int k = FIELD_BITS - 1; k >= 0; k--) begin
      acc = field_mul(acc, acc, taps);
      if (expo[k]) acc = field_mul(acc, base, taps);
    end
    return acc;
  endfunction

  function automatic elem_t predict_field_result(input logic [1:0] act, input poly_t raw_a,
                                                 input elem_t b);
    elem_t taps;
    elem_t a;
    taps = field_poly[FIELD_BITS-1:0];
    a    = raw_a[FIELD_BITS-1:0] ^ (raw_a[FIELD_BITS] ? taps : '0);
    case (act)
      ACT_MUL: return field_mul(a, b, taps);
      ACT_DIV: begin
        if (a == '0) return '0;
        if (b == '0) return DIV_ZERO_CODE;
        return field_mul(a, field_pow(b, DIV_EXPONENT, taps), taps);
      end
      // A raw base that is nonzero still gives one for exponent zero, even
      // when it folds to the zero element.
      ACT_POW: return (raw_a == '0) ? elem_t'(0) : field_pow(a, b, taps);
      default: return '0;
    endcase
  endfunction

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result %h with no transaction outstanding", $time, result_o);
        failures++;
      end else begin
        oldest_result = pending_results.pop_front();
        if (result_o !== oldest_result.result) begin
          $display("%0t: action %0d a %h b %h: expected %h, actual %h", $time,
                   oldest_result.action, oldest_result.operand_a, oldest_result.operand_b,
                   oldest_result.result, result_o);
          failures++;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Waits for a falling edge first; returns at the rising edge of acceptance.
  task automatic send_item(input logic [1:0] act, input poly_t a, input elem_t b);
    field_txn_t txn;
    @(negedge clk_i);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i  <= 1'b1;
    action_i    <= act;
    operand_a_i <= a;
    operand_b_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    txn.action    = act;
    txn.operand_a = a;
    txn.operand_b = b;
    txn.result    = predict_field_result(act, a, b);
    pending_results.push_back(txn);
  endtask

  task automatic send_random_item();
    logic [1:0]  act;
    poly_t       a;
    elem_t       b;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 30) act = ACT_MUL;
    else if (pick < 60) act = ACT_DIV;
    else if (pick < 98) act = ACT_POW;
    else act = ACT_UNUSED;
    case ($urandom_range(15))
      0: a = '0;
      1: a = poly_t'(9'h100);
      2: a = {1'b1, field_poly[FIELD_BITS-1:0]};  // folds to the zero element
      3: a = poly_t'($urandom_range(511, 257));
      4: a = poly_t'(9'h0FF);
      5: a = poly_t'(ELEM_ONE);
      default: a = poly_t'($urandom_range(255, 1));
    endcase
    case ($urandom_range(11))
      0: b = '0;
      1: b = 8'hFF;
      2: b = ELEM_ONE;
      3: b = DIV_EXPONENT;
      default: b = elem_t'($urandom);
    endcase
    send_item(act, a, b);
  endtask

  task automatic wait_until_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_field_polynomial(input poly_t poly);
    wait_until_drained();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= poly;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    field_poly = poly;
  endtask

  task automatic test_special_cases();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_item(ACT_MUL, 9'h000, 8'h53);
    send_item(ACT_MUL, 9'h053, 8'h00);
    send_item(ACT_MUL, 9'h0FF, 8'hFF);
    send_item(ACT_MUL, 9'h080, 8'h02);
    send_item(ACT_MUL, 9'h100, 8'h01);
    send_item(ACT_DIV, 9'h000, 8'h00);
    send_item(ACT_DIV, 9'h000, 8'h07);
    send_item(ACT_DIV, 9'h007, 8'h00);
    send_item(ACT_DIV, 9'h0FF, 8'hFF);
    send_item(ACT_DIV, 9'h001, 8'h02);
    send_item(ACT_DIV, 9'h053, 8'h01);
    send_item(ACT_POW, 9'h000, 8'h00);
    send_item(ACT_POW, 9'h000, 8'hFF);
    send_item(ACT_POW, 9'h002, 8'h00);
    send_item(ACT_POW, 9'h002, 8'hFF);
    send_item(ACT_POW, 9'h0FF, 8'hFE);
    send_item(ACT_POW, 9'h100, 8'h02);
    send_item(ACT_POW, 9'h100, 8'h00);
    // With the reset polynomial, 0x11D folds to zero.
    send_item(ACT_MUL, 9'h11D, 8'h05);
    send_item(ACT_DIV, 9'h11D, 8'h05);
    send_item(ACT_POW, 9'h11D, 8'h00);
    send_item(ACT_POW, 9'h11D, 8'h03);
    send_item(ACT_MUL, 9'h1FF, 8'hFF);
    send_item(ACT_UNUSED, 9'h1FF, 8'hFF);
    send_item(ACT_UNUSED, 9'h0A5, 8'h5A);
  endtask

  task automatic test_polynomial_sweep();
    poly_t polys[6];
    polys = '{9'h100, 9'h1FF, 9'h11B, 9'h12B, 9'h000, 9'h000};
    polys[4] = poly_t'($urandom_range(511, 256));
    polys[5] = poly_t'($urandom_range(511, 256));
    send_idle_pct  = 17;
    recv_stall_pct = 17;
    foreach (polys[p]) begin
      write_field_polynomial(polys[p]);
      repeat (50) send_random_item();
    end
  endtask

  task automatic test_flow_control();
    int unsigned idle_modes[4][2];
    poly_t       polys[4];
    idle_modes = '{'{0, 0}, '{77, 0}, '{0, 77}, '{17, 17}};
    polys      = '{9'h11D, 9'h14D, 9'h1F5, 9'h187};
    foreach (idle_modes[m]) begin
      write_field_polynomial(polys[m]);
      send_idle_pct  = idle_modes[m][0];
      recv_stall_pct = idle_modes[m][1];
      repeat (330) send_random_item();
    end
  endtask

  // The sender holds off until the unit has returned every result.
  task automatic test_drain_pause();
    send_idle_pct  = 0;
    recv_stall_pct = 77;
    repeat (20) send_random_item();
    wait_until_drained();
    repeat (20) send_random_item();
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = POLY_RESET;
    in_valid_i     = 1'b0;
    action_i       = ACT_MUL;
    operand_a_i    = '0;
    operand_b_i    = '0;
    field_poly     = POLY_RESET;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_special_cases();
    test_polynomial_sweep();
    test_flow_control();
    test_drain_pause();

    wait_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
